// ===== rtl/scsa_pkg.sv =====
package scsa_pkg;

  localparam int NUM_CLASSES_DEF  = 8;
  localparam int PAGE_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int STACK_DEPTH_DEF  = 512;

  localparam int MAX_CLASSES = 8;
  localparam int CLS_W       = 3;
  localparam int OFF_W       = 19;
  localparam int CNT_OUT_W   = 9;
  localparam int SIZE_W      = 16;
  localparam int TAG_W       = 11;

  localparam int Q_DEPTH = 4;
  localparam int Q_PW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_EXHAUST = 3'd2,
    ST_BIG     = 3'd3,
    ST_UNDER   = 3'd4
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    logic                 kind;
    logic [SIZE_W-1:0]    req_size;
    logic [TAG_W-1:0]     header_size_tag;
    logic [OFF_W-1:0]     obj_offset;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [CLS_W-1:0]     class_index;
    logic [OFF_W-1:0]     slot_offset;
    logic [CNT_OUT_W-1:0] active_count;
  } result_t;

  typedef struct packed {
    op_t                  op;
    status_t              pre;
    logic [CLS_W-1:0]     cls;
    logic [OFF_W-1:0]     obj;
  } cmd_t;

endpackage

// ===== rtl/scsa_ram.sv =====
module scsa_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/scsa_queue.sv =====
module scsa_queue
  import scsa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t cmd_in,
  input  logic pop,
  output cmd_t cmd_out,
  output logic empty,
  output logic full
);

  cmd_t            slots [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr;
  logic [Q_PW-1:0] rd_ptr;
  logic [Q_CW-1:0] cnt;

  assign empty   = (cnt == '0);
  assign full    = (cnt == Q_CW'(Q_DEPTH));
  assign cmd_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PW'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + Q_CW'(1);
      end else if (pop && !push) begin
        cnt <= cnt - Q_CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue underflow");
  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> cnt == $past(cnt) + Q_CW'(1))
    else $error("queue count mismatch");

endmodule

// ===== rtl/scsa_front.sv =====
module scsa_front
  import scsa_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic start,
  input  req_t req,
  input  logic init_done,
  input  logic q_full,
  output logic busy,
  output logic push,
  output cmd_t cmd
);

  logic             s_found;
  logic [CLS_W-1:0] s_cls;
  logic             t_found;
  logic [CLS_W-1:0] t_cls;
  logic             s_big;

  assign busy = !init_done || q_full;
  assign push = start && !busy;

  always_comb begin
    s_found = 1'b0;
    s_cls   = '0;
    t_found = 1'b0;
    t_cls   = '0;
    for (int c = 0; c < MAX_CLASSES; c++) begin
      if (!s_found && req.req_size <= SIZE_W'(8 << c)) begin
        s_found = 1'b1;
        s_cls   = CLS_W'(c);
      end
      if (!t_found && c < NUM_CLASSES && req.header_size_tag == TAG_W'(8 << c)) begin
        t_found = 1'b1;
        t_cls   = CLS_W'(c);
      end
    end
  end

  assign s_big = !s_found || (int'(s_cls) >= NUM_CLASSES);

  always_comb begin
    cmd.op  = op_t'(req.kind);
    cmd.obj = req.obj_offset;
    cmd.pre = ST_OK;
    cmd.cls = '0;
    if (cmd.op == OP_ALLOC) begin
      if (req.req_size == '0) begin
        cmd.pre = ST_ZERO;
      end else if (s_big) begin
        cmd.pre = ST_BIG;
      end else begin
        cmd.cls = s_cls;
      end
    end else begin
      if (t_found) begin
        cmd.cls = t_cls;
      end else begin
        cmd.pre = ST_BIG;
      end
    end
  end

endmodule

// ===== rtl/scsa_init.sv =====
module scsa_init
  import scsa_pkg::*;
#(
  parameter int NUM_CLASSES  = NUM_CLASSES_DEF,
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  output logic                                              init_done,
  output logic                                              we,
  output logic [$clog2(NUM_CLASSES*STACK_DEPTH)-1:0]        waddr,
  output logic [OFF_W-1:0]                                  wdata,
  output logic [NUM_CLASSES-1:0][$clog2(STACK_DEPTH+1)-1:0] caps
);

  localparam int AW    = $clog2(NUM_CLASSES*STACK_DEPTH);
  localparam int IW    = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH+1);

  logic [CLS_W-1:0] cls;
  logic [IW-1:0]    idx;
  logic [6:0]       page;
  logic [OFF_W-1:0] page_base;
  logic [16:0]      slot_end;
  logic             live;

  logic [16:0]      osize;
  logic             first_fits;
  logic             cur_ok;
  logic             nxt_ok;
  logic             last_idx;
  logic             last_cls;

  assign osize      = 17'(8) << cls;
  assign first_fits = (18'(HEADER_BYTES) + {1'b0, osize}) <= 18'(PAGE_BYTES);
  assign cur_ok     = live && (slot_end <= 17'(PAGE_BYTES));
  assign nxt_ok     = live && !cur_ok && first_fits &&
                      (({1'b0, page} + 8'd1) < (8'd1 << cls));
  assign last_idx   = (idx == IW'(STACK_DEPTH-1));
  assign last_cls   = (cls == CLS_W'(NUM_CLASSES-1));

  assign we    = !init_done;
  assign wdata = cur_ok ? page_base + OFF_W'(slot_end - osize)
                        : page_base + OFF_W'(PAGE_BYTES) + OFF_W'(HEADER_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      init_done <= 1'b0;
      cls       <= '0;
      idx       <= '0;
      waddr     <= '0;
      page      <= '0;
      page_base <= '0;
      slot_end  <= 17'(HEADER_BYTES) + 17'd8;
      live      <= 1'b1;
      caps      <= '0;
    end else if (!init_done) begin
      waddr <= waddr + AW'(1);
      if (cur_ok) begin
        slot_end  <= slot_end + osize;
        caps[cls] <= caps[cls] + CNT_W'(1);
      end else if (nxt_ok) begin
        page      <= page + 7'd1;
        page_base <= page_base + OFF_W'(PAGE_BYTES);
        slot_end  <= 17'(HEADER_BYTES) + (osize << 1);
        caps[cls] <= caps[cls] + CNT_W'(1);
      end else begin
        live <= 1'b0;
      end
      if (last_idx) begin
        idx       <= '0;
        cls       <= cls + CLS_W'(1);
        page      <= '0;
        page_base <= '0;
        slot_end  <= 17'(HEADER_BYTES) + (osize << 1);
        live      <= 1'b1;
        if (last_cls) begin
          init_done <= 1'b1;
        end
      end else begin
        idx <= idx + IW'(1);
      end
    end
  end

endmodule

// ===== rtl/scsa_back.sv =====
module scsa_back
  import scsa_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              init_done,
  input  logic                                              q_empty,
  input  cmd_t                                              cmd,
  input  logic [NUM_CLASSES-1:0][$clog2(STACK_DEPTH+1)-1:0] caps,
  input  logic [OFF_W-1:0]                                  rdata,
  output logic                                              pop,
  output logic                                              re,
  output logic                                              we,
  output logic [$clog2(NUM_CLASSES*STACK_DEPTH)-1:0]        addr,
  output logic [OFF_W-1:0]                                  wdata,
  output logic                                              done,
  output result_t                                           result
);

  localparam int AW    = $clog2(NUM_CLASSES*STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH+1);

  logic [NUM_CLASSES-1:0][CNT_W-1:0] counts;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] n_next;
  logic             upd;
  logic [AW-1:0]    base;
  result_t          res_next;
  result_t          res;
  logic             use_ram;

  assign pop   = !q_empty;
  assign n     = counts[cmd.cls];
  assign base  = AW'(cmd.cls) * AW'(STACK_DEPTH);
  assign wdata = cmd.obj;

  always_comb begin
    res_next = '{status: cmd.pre, class_index: '0, slot_offset: '0, active_count: '0};
    re       = 1'b0;
    we       = 1'b0;
    upd      = 1'b0;
    n_next   = n;
    addr     = base + AW'(n);
    if (cmd.pre == ST_OK) begin
      res_next.class_index = cmd.cls;
      if (cmd.op == OP_ALLOC) begin
        if (n >= caps[cmd.cls]) begin
          res_next.status       = ST_EXHAUST;
          res_next.active_count = CNT_OUT_W'(n);
        end else begin
          n_next                = n + CNT_W'(1);
          upd                   = pop;
          re                    = pop;
          res_next.active_count = CNT_OUT_W'(n_next);
        end
      end else begin
        if (n == '0) begin
          res_next.status = ST_UNDER;
        end else begin
          n_next                = n - CNT_W'(1);
          upd                   = pop;
          we                    = pop;
          addr                  = base + AW'(n_next);
          res_next.active_count = CNT_OUT_W'(n_next);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counts  <= '0;
      done    <= 1'b0;
      use_ram <= 1'b0;
    end else begin
      done    <= pop;
      use_ram <= re;
      if (upd) begin
        counts[cmd.cls] <= n_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

  always_comb begin
    result             = res;
    result.slot_offset = use_ram ? rdata : '0;
  end

  a_done_follows_pop: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(pop))
    else $error("result without request");
  a_pop_after_init: assert property (@(posedge clk) disable iff (rst)
    pop |-> init_done)
    else $error("request served during stack fill");
  a_read_gives_ok: assert property (@(posedge clk) disable iff (rst)
    re |=> done && use_ram && result.status == ST_OK)
    else $error("slot read not returned as ok");

endmodule

// ===== rtl/slab_size_class_allocator.sv =====
// Slab allocator with power-of-two size classes (8 to 1024 bytes).
// Request channel: drive req and pulse start; a request is taken at a rising
// edge with start high and busy low. kind 0 allocates req_size bytes, kind 1
// frees obj_offset into the class named by header_size_tag.
// Result channel: done is high for one cycle with result valid; the result
// is taken at the edge ending that cycle and cannot be held off.
// Path from the accepting edge: queue write, then count update and stack
// access, then output.
// Throughput: one request per cycle while busy is low; the stack memory does at most one pop read
// or push write per request and the per-class count updates at the same edge.
// Reset: synchronous rst clears counts and the queue, then a fill pass writes
// every class's slot offsets into the slot stack memory, one entry per cycle,
// NUM_CLASSES*STACK_DEPTH entries (4096 by default). busy is high meanwhile.
// Results leave in request order, one per request.
module slab_size_class_allocator
  import scsa_pkg::*;
#(
  parameter int NUM_CLASSES  = NUM_CLASSES_DEF,
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  req_t    req,
  output logic    done,
  output result_t result
);

  localparam int AW    = $clog2(NUM_CLASSES*STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH+1);

  logic init_done;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;
  cmd_t cmd_in;
  cmd_t cmd_out;

  logic                              init_we;
  logic [AW-1:0]                     init_addr;
  logic [OFF_W-1:0]                  init_data;
  logic [NUM_CLASSES-1:0][CNT_W-1:0] caps;

  logic             back_re;
  logic             back_we;
  logic [AW-1:0]    back_addr;
  logic [OFF_W-1:0] back_wdata;
  logic [OFF_W-1:0] rdata;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [OFF_W-1:0] ram_wdata;

  scsa_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
    .start     (start),
    .req       (req),
    .init_done (init_done),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .cmd       (cmd_in)
  );

  scsa_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (cmd_in),
    .pop     (pop),
    .cmd_out (cmd_out),
    .empty   (q_empty),
    .full    (q_full)
  );

  scsa_init #(
    .NUM_CLASSES  (NUM_CLASSES),
    .PAGE_BYTES   (PAGE_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_init (
    .clk       (clk),
    .rst       (rst),
    .init_done (init_done),
    .we        (init_we),
    .waddr     (init_addr),
    .wdata     (init_data),
    .caps      (caps)
  );

  scsa_back #(
    .NUM_CLASSES (NUM_CLASSES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .init_done (init_done),
    .q_empty   (q_empty),
    .cmd       (cmd_out),
    .caps      (caps),
    .rdata     (rdata),
    .pop       (pop),
    .re        (back_re),
    .we        (back_we),
    .addr      (back_addr),
    .wdata     (back_wdata),
    .done      (done),
    .result    (result)
  );

  assign ram_we    = init_we || back_we;
  assign ram_waddr = init_done ? back_addr : init_addr;
  assign ram_wdata = init_done ? back_wdata : init_data;

  scsa_ram #(
    .WIDTH (OFF_W),
    .DEPTH (NUM_CLASSES*STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (back_re),
    .raddr (back_addr),
    .rdata (rdata)
  );

endmodule
